// ===== hdl/gspc_pkg.sv =====
`timescale 1ns / 1ps
package gspc_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int COORD_WIDTH       = 16;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);
    localparam int ATAN_IDX_W        = 5;
    localparam int DIFF_W            = COORD_WIDTH + 1;
    // pre-scale by 256 plus headroom for the CORDIC gain
    localparam int CX_W              = DIFF_W + 11;
    localparam int Z_W               = 32;
    localparam int GAIN_W            = 16;
    localparam int PROD_W            = CX_W + GAIN_W + 1;
    localparam int DIST_W            = DIFF_W + 1;
    localparam int ANG_W             = 18;
    localparam int HEAD_W            = 16;
    localparam int SD_W              = 16;
    localparam int DUR_W             = 16;
    localparam int RAD_W             = 15;
    localparam int THR_W             = 15;
    localparam int LIM_W             = 3;
    localparam int LIN_W             = 24;
    localparam int NUM_W             = DIST_W + SD_W + 1;
    localparam int Q_W               = NUM_W - 9;
    localparam int DCNT_W            = $clog2(Q_W);
    localparam int ADDR_W            = 4;
    localparam int DATA_W            = 32;

    localparam logic signed [Z_W-1:0] PI_Q28       = 32'sd843314857;
    localparam logic [GAIN_W-1:0]     INV_GAIN_Q16 = 16'd39797;
    localparam logic [SD_W-1:0]       SD_MAX       = '1;
    localparam logic [LIN_W-1:0]      LIN_MAX      = '1;

    localparam logic [1:0] REG_DURATION  = 2'd0;
    localparam logic [1:0] REG_RADIUS    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_RETRY     = 2'd3;

    typedef enum logic [1:0] {
        ACT_GOAL = 2'd0,
        ACT_POSE = 2'd1,
        ACT_TICK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_DRIVE  = 2'd0,
        KIND_ROTATE = 2'd1,
        KIND_HALT   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_MAG,
        S_FIN,
        S_PROD,
        S_DIV,
        S_DRV_OUT,
        S_ROT,
        S_ROT_OUT,
        S_HALT_OUT
    } state_t;

    typedef struct packed {
        logic [DUR_W-1:0] duration_steps;
        logic [RAD_W-1:0] arrive_radius;
        logic [THR_W-1:0] rotate_threshold;
        logic [LIM_W-1:0] rotate_retry_limit;
    } cfg_t;

    typedef struct packed {
        logic  goal_load;
        logic  pose_load;
        logic  cordic_init;
        logic  cordic_step;
        logic  mag;
        logic  fin;
        logic  capture;
        logic  prod;
        logic  div_step;
        logic  out_load;
        kind_t out_kind;
        logic  out_last;
    } cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic div_last;
        logic dist_lt;
        logic err_gt;
    } status_t;

    function automatic logic [Z_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] r;
        unique case (idx)
            5'd0:  r = 32'd210828714;
            5'd1:  r = 32'd124459457;
            5'd2:  r = 32'd65760959;
            5'd3:  r = 32'd33381289;
            5'd4:  r = 32'd16755422;
            5'd5:  r = 32'd8385879;
            5'd6:  r = 32'd4193963;
            5'd7:  r = 32'd2097109;
            5'd8:  r = 32'd1048571;
            5'd9:  r = 32'd524287;
            5'd10: r = 32'd262144;
            5'd11: r = 32'd131072;
            5'd12: r = 32'd65536;
            5'd13: r = 32'd32768;
            5'd14: r = 32'd16384;
            5'd15: r = 32'd8192;
            5'd16: r = 32'd4096;
            5'd17: r = 32'd2048;
            5'd18: r = 32'd1024;
            5'd19: r = 32'd512;
            5'd20: r = 32'd256;
            5'd21: r = 32'd128;
            5'd22: r = 32'd64;
            5'd23: r = 32'd32;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/gspc_regs.sv =====
`timescale 1ns / 1ps
module gspc_regs
    import gspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duration_steps     <= 16'd10;
            cfg_reg.arrive_radius      <= 15'd307;
            cfg_reg.rotate_threshold   <= 15'd4096;
            cfg_reg.rotate_retry_limit <= 3'd5;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DURATION:  cfg_reg.duration_steps     <= pwdata[DUR_W-1:0];
                REG_RADIUS:    cfg_reg.arrive_radius      <= pwdata[RAD_W-1:0];
                REG_THRESHOLD: cfg_reg.rotate_threshold   <= pwdata[THR_W-1:0];
                REG_RETRY:     cfg_reg.rotate_retry_limit <= pwdata[LIM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DURATION:  prdata = DATA_W'(cfg_reg.duration_steps);
            REG_RADIUS:    prdata = DATA_W'(cfg_reg.arrive_radius);
            REG_THRESHOLD: prdata = DATA_W'(cfg_reg.rotate_threshold);
            REG_RETRY:     prdata = DATA_W'(cfg_reg.rotate_retry_limit);
        endcase
    end

endmodule

// ===== hdl/gspc_ctrl.sv =====
`timescale 1ns / 1ps
module gspc_ctrl
    import gspc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       action,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic [LIM_W-1:0] retry_limit,
    input  status_t          status,
    output cmd_t             cmd
);

    state_t state_reg, state_next;
    logic drive_reg, drive_next;
    logic cap_reg, cap_next;
    logic rot_reg, rot_next;
    logic halt_reg, halt_next;
    logic [LIM_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;
    logic accept, slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (halt_reg)
                        state_next = (action == ACT_TICK) ? S_HALT_OUT : S_IDLE;
                    else if (action == ACT_TICK && (drive_reg || rot_reg))
                        state_next = S_CORDIC;
                end
            S_CORDIC:   if (status.cordic_last) state_next = S_MAG;
            S_MAG:      state_next = S_FIN;
            S_FIN:      state_next = drive_reg ? S_PROD : S_ROT;
            S_PROD:     state_next = S_DIV;
            S_DIV:      if (status.div_last) state_next = S_DRV_OUT;
            S_DRV_OUT:  if (slot_free) state_next = S_ROT;
            S_ROT:      state_next = (rot_reg && status.err_gt) ? S_ROT_OUT : S_IDLE;
            S_ROT_OUT:  if (slot_free) state_next = S_IDLE;
            S_HALT_OUT: if (slot_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.out_kind   = KIND_DRIVE;
        drive_next     = drive_reg;
        cap_next       = cap_reg;
        rot_next       = rot_reg;
        halt_next      = halt_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
                if (accept && !halt_reg)
                begin
                    unique case (action)
                        ACT_GOAL:
                        begin
                            cmd.goal_load = 1'b1;
                            drive_next    = 1'b1;
                            cap_next      = 1'b1;
                        end
                        ACT_POSE: cmd.pose_load = 1'b1;
                        ACT_TICK: cmd.cordic_init = 1'b1;
                        default: ;
                    endcase
                end
            S_CORDIC: cmd.cordic_step = 1'b1;
            S_MAG:    cmd.mag = 1'b1;
            S_FIN:
            begin
                cmd.fin     = 1'b1;
                cmd.capture = drive_reg && cap_reg;
                if (drive_reg)
                    cap_next = 1'b0;
            end
            S_PROD:   cmd.prod = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_DRV_OUT:
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = KIND_DRIVE;
                    // last stays clear when a rotate request follows in the same tick
                    cmd.out_last   = !((rot_reg || status.dist_lt) && status.err_gt);
                    out_valid_next = 1'b1;
                    if (status.dist_lt)
                    begin
                        rot_next   = 1'b1;
                        drive_next = 1'b0;
                        count_next = '0;
                    end
                end
            S_ROT:
                if (rot_reg && !status.err_gt)
                begin
                    halt_next = 1'b1;
                    rot_next  = 1'b0;
                end
            S_ROT_OUT:
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = KIND_ROTATE;
                    cmd.out_last   = 1'b1;
                    out_valid_next = 1'b1;
                    if (count_reg < retry_limit)
                        count_next = count_reg + 1'b1;
                    else
                    begin
                        halt_next = 1'b1;
                        rot_next  = 1'b0;
                    end
                end
            S_HALT_OUT:
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = KIND_HALT;
                    cmd.out_last   = 1'b1;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            drive_reg     <= 1'b0;
            cap_reg       <= 1'b0;
            rot_reg       <= 1'b0;
            halt_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drive_reg     <= drive_next;
            cap_reg       <= cap_next;
            rot_reg       <= rot_next;
            halt_reg      <= halt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/gspc_dp.sv =====
`timescale 1ns / 1ps
module gspc_dp
    import gspc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  cfg_t                          cfg,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [HEAD_W-1:0]      heading,
    output status_t                       status,
    output logic [1:0]                    kind,
    output logic [LIN_W-1:0]              linear_speed,
    output logic signed [ANG_W-1:0]       angular_speed,
    output logic                          last
);

    logic signed [COORD_WIDTH-1:0] goal_x_reg, goal_y_reg, pose_x_reg, pose_y_reg;
    logic signed [HEAD_W-1:0]      head_reg;
    logic [SD_W-1:0]               sd_reg;

    logic signed [CX_W-1:0] cx_reg, cy_reg;
    logic signed [Z_W-1:0]  cz_reg;
    logic [ITER_W-1:0]      it_reg;
    logic mirror_reg, dy_pos_reg, zero_reg;

    logic [PROD_W-1:0]       prod_reg;
    logic signed [ANG_W-1:0] bear_reg, err_reg;
    logic [DIST_W-1:0]       dist_reg;

    logic [Q_W-1:0]    dvd_reg, q_reg;
    logic [DUR_W-1:0]  divisor_reg, rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [1:0]              kind_reg;
    logic [LIN_W-1:0]        lin_reg;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    logic [LIN_W-1:0]        lin_next;
    logic                    last_reg;

    logic signed [DIFF_W-1:0] dx, dy, adx;
    logic signed [CX_W-1:0]   xs, ys;
    logic [Z_W-1:0]           atan_v;
    logic signed [Z_W-1:0]    zf;
    logic signed [Z_W+1:0]    zr;
    logic [PROD_W-1:0]        dist_sum;
    logic [DIST_W-1:0]        dist_c;
    logic [NUM_W-1:0]         num;
    logic [DUR_W:0]           rem_sh, rem_sub;
    logic [DUR_W-1:0]         div_v;

    assign dx  = DIFF_W'(goal_x_reg) - DIFF_W'(pose_x_reg);
    assign dy  = DIFF_W'(goal_y_reg) - DIFF_W'(pose_y_reg);
    assign adx = dx[DIFF_W-1] ? -dx : dx;

    assign xs     = cx_reg >>> it_reg;
    assign ys     = cy_reg >>> it_reg;
    assign atan_v = atan_q28(ATAN_IDX_W'(it_reg));

    always_comb
    begin
        if (!mirror_reg)
            zf = cz_reg;
        else if (dy_pos_reg)
            zf = PI_Q28 - cz_reg;
        else
            zf = -PI_Q28 - cz_reg;
    end
    assign zr = (Z_W+2)'(zf) + (Z_W+2)'(32768);

    assign dist_sum = prod_reg + PROD_W'(1 << 23);
    assign dist_c   = dist_sum[DIST_W+23:24];

    assign div_v  = (cfg.duration_steps < DUR_W'(2)) ? DUR_W'(1)
                                                     : cfg.duration_steps - 1'b1;
    assign num    = NUM_W'(dist_reg) * NUM_W'(sd_reg) + (NUM_W'(div_v) << 8);
    assign rem_sh  = {rem_reg, dvd_reg[Q_W-1]};
    assign rem_sub = rem_sh - {1'b0, divisor_reg};

    assign status.cordic_last = (it_reg == ITER_W'(CORDIC_ITERATIONS - 1));
    assign status.div_last    = (dcnt_reg == DCNT_W'(Q_W - 1));
    assign status.dist_lt     = (dist_reg < DIST_W'(cfg.arrive_radius));
    assign status.err_gt      = (err_reg > $signed(ANG_W'(cfg.rotate_threshold)));

    always_comb
    begin
        lin_next = '0;
        ang_next = '0;
        unique case (cmd.out_kind)
            KIND_DRIVE:
            begin
                lin_next = (q_reg > Q_W'(LIN_MAX)) ? LIN_MAX : q_reg[LIN_W-1:0];
                ang_next = err_reg <<< 1;
            end
            KIND_ROTATE: ang_next = err_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            head_reg   <= '0;
            sd_reg     <= '0;
        end
        else
        begin
            if (cmd.goal_load)
            begin
                goal_x_reg <= pos_x;
                goal_y_reg <= pos_y;
            end
            if (cmd.pose_load)
            begin
                pose_x_reg <= pos_x;
                pose_y_reg <= pos_y;
                head_reg   <= heading;
            end
            if (cmd.capture)
                sd_reg <= (dist_c > DIST_W'(SD_MAX)) ? SD_MAX : dist_c[SD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            cx_reg     <= CX_W'(adx) <<< 8;
            cy_reg     <= CX_W'(dy) <<< 8;
            cz_reg     <= '0;
            it_reg     <= '0;
            mirror_reg <= dx[DIFF_W-1];
            dy_pos_reg <= !dy[DIFF_W-1];
            zero_reg   <= (dx == '0) && (dy == '0);
        end
        else if (cmd.cordic_step)
        begin
            if (!cy_reg[CX_W-1])
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + $signed(atan_v);
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - $signed(atan_v);
            end
            it_reg <= it_reg + 1'b1;
        end

        // magnitude correction and angle rounding
        if (cmd.mag)
        begin
            prod_reg <= zero_reg ? '0 : PROD_W'(cx_reg[CX_W-2:0]) * PROD_W'(INV_GAIN_Q16);
            bear_reg <= zero_reg ? '0 : zr[ANG_W+15:16];
        end

        if (cmd.fin)
        begin
            dist_reg <= zero_reg ? '0 : dist_c;
            err_reg  <= bear_reg - ANG_W'(head_reg);
        end

        if (cmd.prod)
        begin
            dvd_reg     <= num[NUM_W-1:9];
            divisor_reg <= div_v;
            rem_reg     <= '0;
            q_reg       <= '0;
            dcnt_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= dvd_reg << 1;
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!rem_sub[DUR_W])
            begin
                rem_reg <= rem_sub[DUR_W-1:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DUR_W-1:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            lin_reg  <= lin_next;
            ang_reg  <= ang_next;
            last_reg <= cmd.out_last;
        end
    end

    assign kind          = kind_reg;
    assign linear_speed  = lin_reg;
    assign angular_speed = ang_reg;
    assign last          = last_reg;

endmodule

// ===== hdl/goal_seeking_pose_controller.sv =====
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_ready  | action, pos_x, pos_y, heading
// out     | out_valid / out_ready| kind, linear_speed, angular_speed, last
// cfg     | APB psel/penable     | paddr, pwdata, prdata
//
// Goal and pose requests are taken while idle. A tick runs the vectoring unit, then
// gain correction (S_MAG, S_FIN) and, when driving, the product step and the restoring
// divider, which yields a Q_W (26) bit quotient.
// Each result waits in the output register; the next result stalls until it is taken.
// Reset clears all control flags, goal, pose and start distance; config gets defaults.
module goal_seeking_pose_controller
    import gspc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [HEAD_W-1:0]      heading,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [LIN_W-1:0]              linear_speed,
    output logic signed [ANG_W-1:0]       angular_speed,
    output logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    gspc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gspc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .retry_limit (cfg.rotate_retry_limit),
        .status      (status),
        .cmd         (cmd)
    );

    gspc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .status        (status),
        .kind          (kind),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .last          (last)
    );

endmodule

// ===== hdl/gspc_checker.sv =====
`timescale 1ns / 1ps
module gspc_checker
    import gspc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [1:0]              kind,
    input logic [LIN_W-1:0]        linear_speed,
    input logic signed [ANG_W-1:0] angular_speed,
    input logic                    last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(linear_speed) && $stable(angular_speed) && $stable(last))
        else $error("stalled result changed");

    a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_HALT |-> linear_speed == '0
            && angular_speed == '0 && last)
        else $error("halt notice not clean");

    a_rot_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ROTATE |-> linear_speed == '0 && last)
        else $error("rotate command malformed");

    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("unknown result kind");

endmodule

bind goal_seeking_pose_controller gspc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .linear_speed  (linear_speed),
    .angular_speed (angular_speed),
    .last          (last)
);

// ===== tb/goal_seeking_pose_controller_tb.sv =====
`timescale 1ns / 1ps
module goal_seeking_pose_controller_tb;
    import gspc_pkg::*;

    typedef struct {
        kind_t           kind;
        logic [23:0]     lin;
        logic [17:0]     ang;
        logic            last;
    } steer_cmd_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [1:0]                    action = '0;
    logic signed [COORD_WIDTH-1:0] pos_x = '0;
    logic signed [COORD_WIDTH-1:0] pos_y = '0;
    logic signed [HEAD_W-1:0]      heading = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [1:0]                    kind;
    logic [LIN_W-1:0]              linear_speed;
    logic signed [ANG_W-1:0]       angular_speed;
    logic                          last;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ADDR_W-1:0]             paddr = '0;
    logic [DATA_W-1:0]             pwdata = '0;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;

    goal_seeking_pose_controller i_dut (.*);

    always #6 clk = ~clk;

    // controller shadow state
    longint      cfg_duration = 10, cfg_radius = 307, cfg_threshold = 4096, cfg_retry = 5;
    bit          driving, capture_armed, rotating, is_halted;
    longint      retry_count, start_dist;
    longint      gx, gy, px, py, phead;
    steer_cmd_t  pending_cmds[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          burst_left = 0;
    int          stall_mode = 0;

    const longint ARCTAN[24] = '{
        210828714, 124459457, 65760959, 33381289, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void polar(input longint dx, input longint dy,
                                  output longint mag, output longint ang);
        longint x, y, z, xs, ys;
        bit mirror;
        mirror = dx < 0;
        z = 0;
        if (dx == 0 && dy == 0) begin
            mag = 0;
            ang = 0;
            return;
        end
        x = (mirror ? -dx : dx) * 256;
        y = dy * 256;
        for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ARCTAN[i];
            end else begin
                x -= ys; y += xs; z -= ARCTAN[i];
            end
        end
        if (mirror)
            z = (dy >= 0) ? (longint'(843314857) - z) : (-longint'(843314857) - z);
        ang = (z + 32768) >>> 16;
        mag = (x * 39797 + (longint'(1) << 23)) >>> 24;
    endfunction

    function automatic void push_cmd(input kind_t k, input longint lin, input longint ang);
        steer_cmd_t c;
        c.kind = k;
        c.lin  = lin[23:0];
        c.ang  = ang[17:0];
        c.last = 1'b0;
        pending_cmds.push_back(c);
    endfunction

    function automatic void predict_steer(input logic [1:0] act, input longint x,
                                          input longint y, input longint h);
        longint dist_v, bear, err, dv, lin;
        int n_prior;
        n_prior = pending_cmds.size();
        if (is_halted) begin
            if (act == ACT_TICK) begin
                push_cmd(KIND_HALT, 0, 0);
                pending_cmds[$].last = 1'b1;
            end
            return;
        end
        if (act == ACT_GOAL) begin
            gx = x; gy = y;
            driving = 1; capture_armed = 1;
            return;
        end
        if (act == ACT_POSE) begin
            px = x; py = y; phead = h;
            return;
        end
        if (act != ACT_TICK)
            return;
        polar(gx - px, gy - py, dist_v, bear);
        err = bear - phead;
        if (driving) begin
            dv = (cfg_duration < 2) ? 1 : cfg_duration - 1;
            if (capture_armed) begin
                start_dist = (dist_v > 65535) ? 65535 : dist_v;
                capture_armed = 0;
            end
            lin = (dist_v * start_dist + 256 * dv) / (512 * dv);
            if (lin > 16777215)
                lin = 16777215;
            push_cmd(KIND_DRIVE, lin, 2 * err);
            if (dist_v < cfg_radius) begin
                rotating = 1; driving = 0; retry_count = 0;
            end
        end
        if (rotating) begin
            if (err > cfg_threshold) begin
                push_cmd(KIND_ROTATE, 0, err);
                if (retry_count < cfg_retry)
                    retry_count = (retry_count + 1) & 7;
                else begin
                    is_halted = 1; rotating = 0;
                end
            end else begin
                is_halted = 1; rotating = 0;
            end
        end
        if (pending_cmds.size() > n_prior)
            pending_cmds[$].last = 1'b1;
    endfunction

    task automatic send_request(input logic [1:0] act, input longint x, input longint y,
                                input longint h);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        pos_x    <= x[15:0];
        pos_y    <= y[15:0];
        heading  <= h[15:0];
        do @(posedge clk); while (!in_ready);
        predict_steer(act, longint'($signed(x[15:0])), longint'($signed(y[15:0])),
                      longint'($signed(h[15:0])));
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        // a tick with no result may still be in flight
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input longint value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value[31:0];
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_DURATION:  cfg_duration  = value & 16'hFFFF;
            REG_RADIUS:    cfg_radius    = value & 15'h7FFF;
            REG_THRESHOLD: cfg_threshold = value & 15'h7FFF;
            REG_RETRY:     cfg_retry     = value & 3'h7;
        endcase
    endtask

    function automatic longint rand_coord();
        if ($urandom_range(0, 3) == 0)
            return longint'($signed(16'($urandom_range(0, 2047) - 1024)));
        return longint'($signed(16'($urandom())));
    endfunction

    task automatic send_random(input bit allow_unknown);
        int p;
        p = $urandom_range(0, 99);
        if (p < 15)
            send_request(ACT_GOAL, rand_coord(), rand_coord(), rand_coord());
        else if (p < 50)
            send_request(ACT_POSE, rand_coord(), rand_coord(), rand_coord());
        else if (p < 95 || !allow_unknown)
            send_request(ACT_TICK, rand_coord(), rand_coord(), rand_coord());
        else
            send_request(2'd3, rand_coord(), rand_coord(), rand_coord());
    endtask

    // receiver stall pattern
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk) begin
        steer_cmd_t e;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_cmds.size() == 0)
                report($sformatf("unexpected result kind=%0d", kind));
            else begin
                e = pending_cmds.pop_front();
                if (kind !== e.kind)
                    report($sformatf("kind %0d, want %0d", kind, e.kind));
                if (linear_speed !== e.lin)
                    report($sformatf("linear %0d, want %0d", linear_speed, e.lin));
                if (angular_speed !== e.ang)
                    report($sformatf("angular %0d, want %0d", angular_speed,
                                     $signed(e.ang)));
                if (last !== e.last)
                    report($sformatf("last %0b, want %0b", last, e.last));
            end
        end
    end

    task automatic test_idle_and_unknown;
        send_request(ACT_TICK, 0, 0, 0);
        send_request(2'd3, 32767, -32768, 32767);
        send_request(ACT_POSE, 5, -7, 100);
        send_request(ACT_TICK, 0, 0, 0);
        drain();
    endtask

    task automatic test_drive_extremes;
        write_reg(REG_DURATION, 0);
        write_reg(REG_RADIUS, 0);
        write_reg(REG_THRESHOLD, 32767);
        write_reg(REG_RETRY, 7);
        send_request(ACT_GOAL, 32767, 32767, 0);
        send_request(ACT_POSE, -32768, -32768, 32767);
        send_request(ACT_TICK, 0, 0, 0);
        send_request(ACT_POSE, 32767, -32768, -32768);
        send_request(ACT_TICK, 0, 0, 0);
        send_request(ACT_GOAL, -32768, -32768, 0);
        send_request(ACT_POSE, 32767, 32767, -1);
        send_request(ACT_TICK, 0, 0, 0);
        send_request(ACT_POSE, 32767, -32768, 1);
        send_request(ACT_TICK, 0, 0, 0);
        send_request(ACT_POSE, -32768, -32768, 0);
        send_request(ACT_TICK, 0, 0, 0);
        drain();
        write_reg(REG_DURATION, 1);
        send_request(ACT_GOAL, 1000, -2000, 0);
        send_request(ACT_TICK, 0, 0, 0);
        drain();
        write_reg(REG_DURATION, 65535);
        send_request(ACT_TICK, 0, 0, 0);
        send_request(ACT_GOAL, -32768, 32767, 0);
        send_request(ACT_TICK, 0, 0, 0);
        drain();
    endtask

    task automatic test_random_drive;
        for (int round = 0; round < 5; round++) begin
            case (round)
                0:       write_reg(REG_DURATION, 2);
                1:       write_reg(REG_DURATION, 65535);
                default: write_reg(REG_DURATION, $urandom_range(2, 300));
            endcase
            write_reg(REG_THRESHOLD, $urandom_range(0, 32767));
            write_reg(REG_RETRY, $urandom_range(0, 7));
            for (int n = 0; n < 120; n++) begin
                send_random(1'b1);
                // hold off until everything has come back
                if (round == 2 && n == 60)
                    drain();
            end
            drain();
        end
    endtask

    task automatic test_rotate_and_halt;
        bit by_retry;
        by_retry = $urandom_range(0, 1);
        write_reg(REG_RADIUS, 32767);
        write_reg(REG_THRESHOLD, by_retry ? 0 : 32767);
        write_reg(REG_RETRY, by_retry ? 7 : $urandom_range(0, 7));
        send_request(ACT_POSE, 0, 0, by_retry ? -32768 : 0);
        send_request(ACT_GOAL, 100, 0, 0);
        send_request(ACT_TICK, 0, 0, 0);
        // when by_retry, a goal while rotating gives drive then rotate on one tick
        send_request(ACT_GOAL, 300, 0, 0);
        send_request(ACT_TICK, 0, 0, 0);
        for (int n = 0; n < 30; n++) begin
            if (!is_halted && $urandom_range(0, 3) == 0)
                send_request(ACT_POSE, $urandom_range(0, 200), $urandom_range(0, 200),
                             -32768 + $urandom_range(0, 100));
            else
                send_random(1'b1);
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_and_unknown();
        test_drive_extremes();
        test_random_drive();
        test_rotate_and_halt();
        if (pending_cmds.size() != 0)
            report($sformatf("%0d results never arrived", pending_cmds.size()));
        $display("Covered idle, unknown and extreme requests, five random drive rounds,");
        $display("and arrival through rotation into halt; %0d results checked.",
                 results_seen);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
